[rtl/sam_pkg.sv]
// Shared types, constants and helpers for the suffix automaton prefix matcher.
// No dependencies; imported by sam_engine and suffix_automaton_prefix_match.
`default_nettype none
package sam_pkg;

   localparam int MAX_TEXT = 1024;
   localparam int ALPHA    = 4;
   localparam int NODE_W   = $clog2(2 * MAX_TEXT);
   localparam int NODE_NUM = 2 ** NODE_W;
   localparam int LEN_W    = $clog2(MAX_TEXT + 1);
   localparam int CNT_W    = 11;
   localparam int CODE_W   = $clog2(ALPHA);

   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_QUERY  = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic [2:0] ST_APPENDED = 3'd0;
   localparam logic [2:0] ST_RUNNING  = 3'd1;
   localparam logic [2:0] ST_DONE     = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_CLEARED  = 3'd4;

   localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
   localparam logic [NODE_W-1:0] NO_NODE   = '0;
   localparam logic [CNT_W-1:0]  COUNT_MAX = '1;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] symbol_byte;
      logic       pattern_end;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [CNT_W-1:0] match_length;
   } rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0]                 len;
      logic [NODE_W-1:0]                link;
      logic [ALPHA-1:0][NODE_W-1:0]     trans;
   } node_type;

   localparam int NODE_BITS = $bits(node_type);

   function automatic logic [CODE_W-1:0] sym_code(input logic [7:0] b);
      logic [CODE_W-1:0] c;
      unique case (b)
         8'h45:   c = CODE_W'(0);
         8'h57:   c = CODE_W'(1);
         8'h53:   c = CODE_W'(2);
         default: c = CODE_W'(3);
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

[rtl/sam_node_ram.sv]
// Single-port synchronous RAM with registered read data, read-first.
// Generic; no package dependency.
`default_nettype none
module sam_node_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule
`default_nettype wire

[rtl/sam_engine.sv]
// Sequencer for append, query and clear words over the node memory.
// Depends on sam_pkg and sam_node_ram.
`default_nettype none
module sam_engine (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire sam_pkg::req_type req_data,
   input  wire logic            out_free,
   output logic                 done,
   output sam_pkg::rsp_type     result
);
   import sam_pkg::*;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_CLR, S_QRD, S_QEV, S_APP, S_W1RD, S_W1,
      S_CKRD, S_CK, S_QLINK, S_W2RD, S_W2, S_FRESH, S_DONE
   } state_type;

   state_type          state_ff;
   req_type            word_ff;
   logic [CODE_W-1:0]  code_ff;
   logic [NODE_W-1:0]  count_ff, last_ff, fresh_ff, p_ff, q_ff, dup_ff, link_ff;
   logic [LEN_W-1:0]   text_len_ff, plen_ff;
   logic [NODE_W-1:0]  qnode_ff;
   logic [CNT_W-1:0]   qcount_ff;
   logic               qstop_ff;
   node_type           qent_ff;
   rsp_type            result_ff;

   logic               mem_we;
   logic [NODE_W-1:0]  mem_addr;
   node_type           mem_wdata, mem_rdata;
   logic [NODE_BITS-1:0] rdata_bits;
   logic [NODE_W-1:0]  rd_next, count_inc;
   logic [CNT_W-1:0]   qcount_in;

   sam_node_ram #(.WIDTH(NODE_BITS), .DEPTH(NODE_NUM)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (rdata_bits)
   );

   assign mem_rdata = node_type'(rdata_bits);
   assign rd_next   = mem_rdata.trans[code_ff];
   assign count_inc = count_ff + NODE_W'(1);
   assign qcount_in = (qcount_ff < COUNT_MAX) ? qcount_ff + CNT_W'(1) : qcount_ff;
   assign req_ready = (state_ff == S_IDLE);
   assign done      = (state_ff == S_DONE) && out_free;
   assign result    = result_ff;

   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = p_ff;
      mem_wdata = mem_rdata;
      unique case (state_ff)
         S_INIT, S_CLR: begin
            mem_we    = 1'b1;
            mem_addr  = ROOT_NODE;
            mem_wdata = '0;
         end
         S_QRD: mem_addr = qnode_ff;
         S_W1: begin
            mem_we = (rd_next == NO_NODE);
            mem_wdata.trans[code_ff] = fresh_ff;
         end
         S_CKRD: mem_addr = q_ff;
         S_CK: begin
            mem_we        = ((plen_ff + LEN_W'(1)) != mem_rdata.len);
            mem_addr      = count_inc;
            mem_wdata.len = plen_ff + LEN_W'(1);
         end
         S_QLINK: begin
            mem_we         = 1'b1;
            mem_addr       = q_ff;
            mem_wdata      = qent_ff;
            mem_wdata.link = dup_ff;
         end
         S_W2: begin
            mem_we = (rd_next == q_ff);
            mem_wdata.trans[code_ff] = dup_ff;
         end
         S_FRESH: begin
            mem_we         = 1'b1;
            mem_addr       = fresh_ff;
            mem_wdata      = '0;
            mem_wdata.len  = text_len_ff + LEN_W'(1);
            mem_wdata.link = link_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_INIT;
         count_ff    <= ROOT_NODE;
         last_ff     <= ROOT_NODE;
         text_len_ff <= '0;
         qnode_ff    <= ROOT_NODE;
         qcount_ff   <= '0;
         qstop_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            S_INIT: state_ff <= S_IDLE;
            S_IDLE: begin
               if (req_valid) begin
                  word_ff <= req_data;
                  code_ff <= sym_code(req_data.symbol_byte);
                  priority case (req_data.cmd)
                     CMD_APPEND: state_ff <= S_APP;
                     CMD_QUERY:  state_ff <= S_QRD;
                     CMD_CLEAR:  state_ff <= S_CLR;
                     default:    state_ff <= S_IDLE;
                  endcase
               end
            end
            S_CLR: begin
               count_ff    <= ROOT_NODE;
               last_ff     <= ROOT_NODE;
               text_len_ff <= '0;
               qnode_ff    <= ROOT_NODE;
               qcount_ff   <= '0;
               qstop_ff    <= 1'b0;
               result_ff   <= '{status: ST_CLEARED, match_length: '0};
               state_ff    <= S_DONE;
            end
            S_QRD: state_ff <= S_QEV;
            S_QEV: begin
               logic [CNT_W-1:0] cnt;
               cnt = qcount_ff;
               if (!qstop_ff && rd_next != NO_NODE) begin
                  cnt = qcount_in;
               end
               if (word_ff.pattern_end) begin
                  qnode_ff  <= ROOT_NODE;
                  qcount_ff <= '0;
                  qstop_ff  <= 1'b0;
                  result_ff <= '{status: ST_DONE, match_length: cnt};
               end else begin
                  if (!qstop_ff) begin
                     if (rd_next == NO_NODE) begin
                        qstop_ff <= 1'b1;
                     end else begin
                        qnode_ff <= rd_next;
                     end
                  end
                  qcount_ff <= cnt;
                  result_ff <= '{status: ST_RUNNING, match_length: cnt};
               end
               state_ff <= S_DONE;
            end
            S_APP: begin
               qnode_ff  <= ROOT_NODE;
               qcount_ff <= '0;
               qstop_ff  <= 1'b0;
               if (text_len_ff >= LEN_W'(MAX_TEXT)) begin
                  result_ff <= '{status: ST_FULL, match_length: '0};
                  state_ff  <= S_DONE;
               end else begin
                  fresh_ff <= count_inc;
                  count_ff <= count_inc;
                  p_ff     <= last_ff;
                  state_ff <= S_W1RD;
               end
            end
            S_W1RD: state_ff <= S_W1;
            S_W1: begin
               if (rd_next == NO_NODE) begin
                  p_ff <= mem_rdata.link;
                  if (mem_rdata.link == NO_NODE) begin
                     link_ff  <= ROOT_NODE;
                     state_ff <= S_FRESH;
                  end else begin
                     state_ff <= S_W1RD;
                  end
               end else begin
                  q_ff     <= rd_next;
                  plen_ff  <= mem_rdata.len;
                  state_ff <= S_CKRD;
               end
            end
            S_CKRD: state_ff <= S_CK;
            S_CK: begin
               if ((plen_ff + LEN_W'(1)) == mem_rdata.len) begin
                  link_ff  <= q_ff;
                  state_ff <= S_FRESH;
               end else begin
                  dup_ff   <= count_inc;
                  count_ff <= count_inc;
                  qent_ff  <= mem_rdata;
                  state_ff <= S_QLINK;
               end
            end
            S_QLINK: state_ff <= S_W2RD;
            S_W2RD:  state_ff <= S_W2;
            S_W2: begin
               if (rd_next == q_ff && mem_rdata.link != NO_NODE) begin
                  p_ff     <= mem_rdata.link;
                  state_ff <= S_W2RD;
               end else begin
                  link_ff  <= dup_ff;
                  state_ff <= S_FRESH;
               end
            end
            S_FRESH: begin
               last_ff     <= fresh_ff;
               text_len_ff <= text_len_ff + LEN_W'(1);
               result_ff   <= '{status: ST_APPENDED, match_length: '0};
               state_ff    <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

[rtl/suffix_automaton_prefix_match.sv]
// Suffix automaton prefix matcher: request words in, one response word out per
// command 0, 1 or 2; command 3 is taken and dropped without a response.
// Append (0) extends the automaton over codes E=0, W=1, S=2, other=3 and
// answers status 0, or status 3 once MAX_TEXT symbols are held. Query (1)
// walks one pattern symbol and answers the count so far (status 1) or the
// final count with pattern_end (status 2). Clear (2) empties it (status 4).
// One word is worked at a time. A query passes S_QRD and S_QEV, a clear
// S_CLR and a rejected append S_APP, before the response is loaded in S_DONE.
// An append passes S_APP, then S_W1RD/S_W1 for each suffix link followed,
// S_CKRD/S_CK when it meets an existing transition, and when it clones
// S_QLINK plus S_W2RD/S_W2 for each node checked for redirection, then
// S_FRESH; the work is amortized constant per symbol.
// Every step is bound by the single port of the node memory.
// After reset the block writes the root node in S_INIT and then
// raises req_ready. The response sits in an output register; while rsp_ready
// is low the next word may still be taken and worked up to its response,
// then holds until the register frees.
// Depends on sam_pkg and sam_engine.
`default_nettype none
module suffix_automaton_prefix_match (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire sam_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sam_pkg::rsp_type      rsp_data
);
   import sam_pkg::*;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    out_free, done;
   rsp_type result;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   sam_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_free  (out_free),
      .done      (done),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= result;
      end
   end

endmodule
`default_nettype wire
